// File: rtl/bounded_ordered_list_assert.svh
// assertion macros shared by the bounded ordered list rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define BOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define BOL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BOL_ASSERT(lbl, prop, msg)
`define BOL_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/bol_pkg.sv
`timescale 1ns / 1ps
// types and constants for the bounded ordered list
// no dependencies
package bol_pkg;

  localparam int KIND_W       = 3;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int STATUS_W     = 3;
  localparam int FOUND_W      = 7;
  localparam int COUNT_W      = 8;
  localparam int CAPACITY_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_INS_POS  = 3'd2,
    KIND_DEL_HEAD = 3'd3,
    KIND_DEL_TAIL = 3'd4,
    KIND_DEL_POS  = 3'd5,
    KIND_SEARCH   = 3'd6,
    KIND_CLEAR    = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // how the step unit walks the cursor
  typedef struct packed {
    logic up;      // cursor counts up (delete, search) or down (insert)
    logic search;  // read at the cursor itself instead of its neighbor
  } step_mode_t;

  typedef struct packed {
    logic more;    // another step follows this one
    logic match;   // read entry equals the searched value
  } step_flags_t;

endpackage

// File: rtl/bol_if.sv
`timescale 1ns / 1ps
// valid/ready channels for operation items and result items
// depends on bol_pkg
interface bol_in_if import bol_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, kind, value, position, input ready);
  modport sink (input valid, kind, value, position, output ready);
endinterface

interface bol_out_if import bol_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FOUND_W-1:0]  found_position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_position, entry_count, input ready);
  modport sink (input valid, status, found_position, entry_count, output ready);
endinterface

// File: rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// Bounded ordered list of up to CAPACITY signed 32-bit entries kept in one
// single-port-read ram. Each item on in_i applies one operation (insert at
// head, tail or position; delete at head, tail or position; search; clear)
// and yields exactly one result item on out_o with a status, the first
// matching position of a search and the entry count afterwards. Entries are
// moved one at a time through a shared step unit: every moved entry costs a
// ram read and a ram write, because the ram has one write port and a
// registered read port. An insert shifts the entries from the end down to
// its slot and then writes the new value there, a delete shifts the entries
// above the removed slot down by one, a search reads from the head until the
// first match or the end, and clear or a rejected operation goes straight to
// the result. in_i.ready is high only while no item is in work; a finished
// result waits in the output register, so a new item may be accepted while
// the previous result is still unread. There is no clearing pass after
// reset: the count starts at zero and only entries below the count are ever
// read.
// depends on bol_pkg, bol_if, bol_ram, bol_step, bounded_ordered_list_assert.svh
`include "bounded_ordered_list_assert.svh"

module bounded_ordered_list import bol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bol_in_if.sink    in_i,
  bol_out_if.source out_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int CmpW  = (CntW > POS_W) ? CntW : POS_W;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // waiting for an item
    S_RD   = 6'b000010,  // ram read issued
    S_WR   = 6'b000100,  // shifted entry written back
    S_CMP  = 6'b001000,  // search compare on read data
    S_PUT  = 6'b010000,  // new value written at its slot
    S_RESP = 6'b100000   // result waits for the output register
  } state_e;

  state_e                    state_q, state_d;
  step_mode_t                mode_q, mode_d;
  logic [CntW-1:0]           cursor_q, cursor_d;
  logic [CntW-1:0]           limit_q, limit_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [VALUE_W-1:0]        value_q, value_d;
  status_e                   status_q, status_d;
  logic [CntW-1:0]           found_q, found_d;

  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q;
  logic [FOUND_W-1:0]        out_found_q;
  logic [COUNT_W-1:0]        out_count_q;
  logic                      out_load;

  // step unit and ram signals
  logic [CntW-1:0]           step_next;
  logic [AddrW-1:0]          step_raddr;
  step_flags_t               step_flags;
  logic                      ram_we;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [VALUE_W-1:0]        ram_rdata;

  // decode helpers for a new item
  logic                      list_full;
  logic                      list_empty;
  logic                      pos_over;
  logic                      pos_below_count;
  logic [CntW-1:0]           last_idx;
  logic [CntW-1:0]           ins_idx;
  logic [CntW-1:0]           del_idx;

  assign list_full       = (count_q == CntW'(CAPACITY));
  assign list_empty      = (count_q == '0);
  assign pos_over        = (32'(in_i.position) > 32'(CAPACITY));
  assign pos_below_count = (CmpW'(in_i.position) < CmpW'(count_q));
  assign last_idx        = CntW'(count_q - 1'b1);

  // positions at or past the end clamp to the append slot or the last entry
  always_comb begin
    ins_idx = count_q;
    del_idx = last_idx;
    unique case (kind_e'(in_i.kind))
      KIND_INS_HEAD: ins_idx = '0;
      KIND_INS_POS:  ins_idx = pos_below_count ? CntW'(in_i.position) : count_q;
      KIND_DEL_HEAD: del_idx = '0;
      KIND_DEL_POS:  del_idx = pos_below_count ? CntW'(in_i.position) : last_idx;
      default: begin
        ins_idx = count_q;
        del_idx = last_idx;
      end
    endcase
  end

  bol_step #(
    .CAPACITY (CAPACITY)
  ) u_step (
    .mode_i   (mode_q),
    .cursor_i (cursor_q),
    .limit_i  (limit_q),
    .entry_i  (ram_rdata),
    .value_i  (value_q),
    .next_o   (step_next),
    .raddr_o  (step_raddr),
    .flags_o  (step_flags)
  );

  // the write slot is always the cursor; a put writes the new value there
  assign ram_we    = (state_q == S_WR) || (state_q == S_PUT);
  assign ram_wdata = (state_q == S_PUT) ? value_q : ram_rdata;

  bol_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cursor_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (step_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    cursor_d = cursor_q;
    limit_d  = limit_q;
    count_d  = count_q;
    value_d  = value_q;
    status_d = status_q;
    found_d  = found_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          value_d  = in_i.value;
          status_d = ST_OK;
          found_d  = '0;
          state_d  = S_RESP;
          unique case (kind_e'(in_i.kind)) inside
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else if ((kind_e'(in_i.kind) == KIND_INS_POS) && pos_over) begin
                status_d = ST_RANGE;
              end else begin
                // shift entries up from the end down to the slot
                mode_d   = '{up: 1'b0, search: 1'b0};
                cursor_d = count_q;
                limit_d  = ins_idx;
                state_d  = (count_q > ins_idx) ? S_RD : S_PUT;
              end
            end
            KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_POS: begin
              if (list_empty) begin
                status_d = ST_EMPTY;
              end else if ((kind_e'(in_i.kind) == KIND_DEL_POS) && pos_over) begin
                status_d = ST_RANGE;
              end else if (del_idx < last_idx) begin
                // shift entries down over the removed slot
                mode_d   = '{up: 1'b1, search: 1'b0};
                cursor_d = del_idx;
                limit_d  = last_idx;
                state_d  = S_RD;
              end else begin
                count_d = last_idx;
              end
            end
            KIND_SEARCH: begin
              status_d = ST_NOTFOUND;
              if (!list_empty) begin
                mode_d   = '{up: 1'b1, search: 1'b1};
                cursor_d = '0;
                limit_d  = count_q;
                state_d  = S_RD;
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = mode_q.search ? S_CMP : S_WR;
      end
      S_WR: begin
        cursor_d = step_next;
        if (step_flags.more) begin
          state_d = S_RD;
        end else if (!mode_q.up) begin
          state_d = S_PUT;
        end else begin
          count_d = last_idx;
          state_d = S_RESP;
        end
      end
      S_CMP: begin
        if (step_flags.match) begin
          status_d = ST_OK;
          found_d  = cursor_q;
          state_d  = S_RESP;
        end else if (step_flags.more) begin
          cursor_d = step_next;
          state_d  = S_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_PUT: begin
        count_d = CntW'(count_q + 1'b1);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: holds one result so the next item can start meanwhile
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    cursor_q <= cursor_d;
    limit_q  <= limit_d;
    value_q  <= value_d;
    status_q <= status_d;
    found_q  <= found_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_found_q  <= FOUND_W'(found_q);
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.found_position = out_found_q;
  assign out_o.entry_count    = out_count_q;

  // checks
  `BOL_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `BOL_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, state_q != S_IDLE,
                   "accepted item not in work")
  `BOL_ASSERT(a_write_in_range, ram_we |-> (cursor_q < CntW'(CAPACITY)),
              "ram write past capacity")
  `BOL_ASSERT(a_count_step, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1 ||
              count_q == $past(count_q) - 1'b1 || count_q == '0), "entry count jumped")

endmodule

// File: rtl/bol_ram.sv
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
// no dependencies
module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bol_step.sv
`timescale 1ns / 1ps
// shared step unit: cursor increment/decrement, loop bound and value compare
// depends on bol_pkg
module bol_step import bol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  step_mode_t                       mode_i,
  input  logic [$clog2(CAPACITY+1)-1:0]    cursor_i,
  input  logic [$clog2(CAPACITY+1)-1:0]    limit_i,
  input  logic [VALUE_W-1:0]               entry_i,
  input  logic [VALUE_W-1:0]               value_i,
  output logic [$clog2(CAPACITY+1)-1:0]    next_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_o,
  output step_flags_t                      flags_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);

  logic [CntW-1:0] next;

  assign next = mode_i.up ? CntW'(cursor_i + 1'b1) : CntW'(cursor_i - 1'b1);

  // search reads the cursor itself, a shift reads the neighbor it copies from
  assign raddr_o = mode_i.search ? cursor_i[AddrW-1:0] : next[AddrW-1:0];
  assign next_o  = next;

  assign flags_o.more  = mode_i.up ? (next < limit_i) : (next > limit_i);
  assign flags_o.match = (entry_i == value_i);

endmodule

// File: tb/sv/bol_result_check.sv
`timescale 1ns / 1ps
// result checker for the bounded ordered list: keeps a shadow list, predicts each result
// depends on bol_pkg and the bol_in_if / bol_out_if channel interfaces
module bol_result_check import bol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bol_in_if           item_mon,
  bol_out_if          result_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    status_e            status;
    logic [FOUND_W-1:0] found;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic signed [VALUE_W-1:0] shadow_list[$];
  list_result_t              expected_q[$];
  int unsigned               fails;

  // applies one operation to the shadow list and returns the result it should give
  function automatic list_result_t apply_op(kind_e kind, logic signed [VALUE_W-1:0] value,
                                            logic [POS_W-1:0] pos);
    list_result_t res;
    int unsigned  idx;
    int unsigned  size;
    res.status = ST_OK;
    res.found  = '0;
    size       = shadow_list.size();
    case (kind)
      KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
        if (size >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (kind == KIND_INS_POS && pos > CAPACITY) begin
          res.status = ST_RANGE;
        end else begin
          if (kind == KIND_INS_HEAD) idx = 0;
          else if (kind == KIND_INS_TAIL || pos > size) idx = size;
          else idx = pos;
          shadow_list.insert(idx, value);
        end
      end
      KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_POS: begin
        if (size == 0) begin
          res.status = ST_EMPTY;
        end else if (kind == KIND_DEL_POS && pos > CAPACITY) begin
          res.status = ST_RANGE;
        end else begin
          if (kind == KIND_DEL_HEAD) idx = 0;
          else if (kind == KIND_DEL_TAIL || pos >= size) idx = size - 1;
          else idx = pos;
          shadow_list.delete(idx);
        end
      end
      KIND_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (int i = 0; i < size; i++) begin
          if (res.status == ST_NOTFOUND && shadow_list[i] == value) begin
            res.status = ST_OK;
            res.found  = FOUND_W'(i);
          end
        end
      end
      default: begin
        shadow_list.delete();
      end
    endcase
    res.count = COUNT_W'(shadow_list.size());
    return res;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want_res;
    if (!rst_ni) begin
      shadow_list.delete();
      expected_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results first: no result can belong to an item accepted at the same edge
      if (result_mon.valid && result_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d found %0d count %0d",
                   $time, result_mon.status, result_mon.found_position, result_mon.entry_count);
          fails++;
        end else begin
          want_res = expected_q.pop_front();
          check_field("status", 8'(want_res.status), 8'(result_mon.status));
          check_field("found_position", 8'(want_res.found), 8'(result_mon.found_position));
          check_field("entry_count", want_res.count, result_mon.entry_count);
        end
      end
      if (item_mon.valid && item_mon.ready)
        expected_q.push_back(apply_op(kind_e'(item_mon.kind), item_mon.value,
                                      item_mon.position));
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/sv/bounded_ordered_list_test.sv
`timescale 1ns / 1ps
// top of the bounded ordered list testbench: clock, reset, operation stimulus, verdict
// depends on bol_pkg, bol_if, bol_result_check and the bounded_ordered_list rtl
module bounded_ordered_list_test import bol_pkg::*;;

  // worst single item is a search of a full list or an insert at its head; the
  // limit leaves room for that plus long random stalls
  localparam int unsigned STALL_LIMIT = 4000;
  // tail wait after the last result, enough for a stray result to show up
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned pending_cnt;
  int unsigned fail_cnt;
  int unsigned stall_cycles;

  bol_in_if  op_if ();
  bol_out_if res_if ();

  bounded_ordered_list #(
    .CAPACITY(CAPACITY_DEF)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  bol_result_check #(
    .CAPACITY(CAPACITY_DEF)
  ) u_result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_mon    (op_if),
    .result_mon  (res_if),
    .pending_o   (pending_cnt),
    .fail_count_o(fail_cnt)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // result side back-pressure, idles about a quarter of the cycles unless no_idle is set
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // presents one item, with random idle cycles ahead of it unless no_idle is set, and waits for acceptance
  task automatic send_op(kind_e kind, logic signed [VALUE_W-1:0] value,
                         logic [POS_W-1:0] pos);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      op_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_if.valid    <= 1'b1;
    op_if.kind     <= kind;
    op_if.value    <= value;
    op_if.position <= pos;
    do @(posedge clk_i); while (!op_if.ready);
  endtask

  // holds the sender off until every predicted result has come back
  task automatic drain_results();
    op_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  function automatic kind_e pick_kind(int unsigned ins_pct, int unsigned del_pct,
                                      int unsigned clear_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < ins_pct) return kind_e'($urandom_range(2));
    if (r < ins_pct + del_pct) return kind_e'(int'(KIND_DEL_HEAD) + $urandom_range(2));
    if (r < ins_pct + del_pct + clear_pct) return KIND_CLEAR;
    return KIND_SEARCH;
  endfunction

  // values come mostly from a small pool so that searches hit, the rest span all bits
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      3:       return -32'sh1;
      4, 5, 6: return 32'($urandom_range(5));
      default: return $urandom;
    endcase
  endfunction

  // positions mostly near the list range, some up to the field maximum
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(99) < 85) return POS_W'($urandom_range(130));
    return POS_W'($urandom_range(255));
  endfunction

  task automatic run_phase(int unsigned n_items, int unsigned ins_pct,
                           int unsigned del_pct, int unsigned clear_pct);
    repeat (n_items) send_op(pick_kind(ins_pct, del_pct, clear_pct), pick_value(), pick_pos());
  endtask

  initial begin
    op_if.valid    <= 1'b0;
    op_if.kind     <= KIND_CLEAR;
    op_if.value    <= '0;
    op_if.position <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every delete and a search on an empty list, empty wins over range
    send_op(KIND_DEL_HEAD, 32'sh0, 8'd0);
    send_op(KIND_DEL_TAIL, 32'sh0, 8'd0);
    send_op(KIND_DEL_POS, 32'sh0, 8'd200);
    send_op(KIND_SEARCH, 32'sh0, 8'd0);
    send_op(KIND_CLEAR, 32'sh0, 8'd0);
    // positional insert above capacity is rejected, at 129 and at the field maximum
    send_op(KIND_INS_POS, 32'sh1, 8'd129);
    send_op(KIND_INS_POS, 32'sh1, 8'd255);
    // positional insert into an empty list appends
    send_op(KIND_INS_POS, 32'sh8000_0000, 8'd5);
    send_op(KIND_INS_HEAD, 32'sh7fff_ffff, 8'd0);
    send_op(KIND_INS_TAIL, -32'sh1, 8'd0);
    send_op(KIND_INS_POS, 32'sh0, 8'd128);
    send_op(KIND_INS_POS, 32'sh5a5a_5a5a, 8'd1);
    // hits at the head and further in, then a miss
    send_op(KIND_SEARCH, 32'sh7fff_ffff, 8'd0);
    send_op(KIND_SEARCH, -32'sh1, 8'd0);
    send_op(KIND_SEARCH, 32'sh7b, 8'd0);
    // positional delete above capacity, past the end, and in the middle
    send_op(KIND_DEL_POS, 32'sh0, 8'd129);
    send_op(KIND_DEL_POS, 32'sh0, 8'd128);
    send_op(KIND_DEL_POS, 32'sh0, 8'd1);
    send_op(KIND_DEL_HEAD, 32'sh0, 8'd0);
    send_op(KIND_DEL_TAIL, 32'sh0, 8'd0);
    // delete tail of a one-entry list empties it
    send_op(KIND_DEL_TAIL, 32'sh0, 8'd0);
    // duplicates report the first match, then clear a non-empty list
    send_op(KIND_INS_TAIL, 32'sh1, 8'd0);
    send_op(KIND_INS_TAIL, 32'sh1, 8'd0);
    send_op(KIND_SEARCH, 32'sh1, 8'd0);
    send_op(KIND_CLEAR, 32'sh0, 8'd0);

    // random: mixed traffic, an insert-heavy fill, a mixed burst without idles, a delete-heavy drain, more mixed
    run_phase(100, 45, 30, 2);
    run_phase(170, 85, 8, 0);
    drain_results();
    no_idle <= 1'b1;
    run_phase(60, 40, 40, 1);
    no_idle <= 1'b0;
    run_phase(90, 8, 82, 0);
    run_phase(30, 40, 30, 3);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: bounded_ordered_list.f
+incdir+rtl
rtl/bol_pkg.sv
rtl/bol_if.sv
rtl/bol_ram.sv
rtl/bol_step.sv
rtl/bounded_ordered_list.sv
tb/sv/bol_result_check.sv
tb/sv/bounded_ordered_list_test.sv
